@@ design/sactp_pkg.sv @@
// Shared types and constants for the set-associative cache tag and policy block.
`default_nettype none
package sactp_pkg;

    localparam int ADDR_WIDTH   = 32;
    localparam int TAG_W        = ADDR_WIDTH - 2;
    localparam int SET_FIELD_W  = 8;
    localparam int BLK_COST_W   = 17;
    localparam int COST_W       = 18;
    localparam int CNT_W        = 32;
    localparam int TOTAL_W      = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 4;
    localparam int WAYS_CNT_W   = 7;

    localparam int DEF_SETS     = 256;
    localparam int DEF_WAYS     = 8;

    localparam int MEM_CYCLES   = 100;
    localparam int CACHE_CYCLES = 1;
    localparam int OFF_MIN      = 2;
    localparam int OFF_MAX      = 12;
    localparam int IDX_CAP      = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_BITS    = 3'd0,
        REG_INDEX_BITS     = 3'd1,
        REG_WAYS_IN_USE    = 3'd2,
        REG_WRITE_ALLOCATE = 3'd3,
        REG_WRITE_BACK     = 3'd4,
        REG_USE_FIFO       = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CNT_LOAD_HIT   = 2'd0,
        CNT_LOAD_MISS  = 2'd1,
        CNT_STORE_HIT  = 2'd2,
        CNT_STORE_MISS = 2'd3
    } cnt_sel_t;

    typedef struct packed {
        logic [3:0] offset_bits;
        logic [3:0] index_bits;
        logic [3:0] ways_in_use;
        logic       store_alloc;
        logic       copy_back;
        logic       use_fifo;
    } cfg_t;

    typedef struct packed {
        logic                  op;
        logic [ADDR_WIDTH-1:0] address;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic               allocated;
        logic               wrote_back;
        logic [COST_W-1:0]  cycles_added;
        logic [TOTAL_W-1:0] total_cycles;
        logic [CNT_W-1:0]   load_hits;
        logic [CNT_W-1:0]   load_misses;
        logic [CNT_W-1:0]   store_hits;
        logic [CNT_W-1:0]   store_misses;
    } out_item_t;

    // classified access handed from front to back
    typedef struct packed {
        logic                   store;
        logic [SET_FIELD_W-1:0] set;
        logic [TAG_W-1:0]       tag;
        logic [BLK_COST_W-1:0]  blk_cost;
    } acc_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } bk_status_t;

endpackage
`default_nettype wire

@@ design/sactp_front.sv @@
// Front end: accepts accesses, splits address into set and tag, queues them.
`default_nettype none
module sactp_front
    import sactp_pkg::*;
#(
    parameter int SETS = DEF_SETS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_data,
    input  wire bk_status_t bk,
    output logic            q_valid,
    output acc_t            q_item
);

    localparam int SETS_LOG = (SETS > 1) ? $clog2(SETS + 1) - 1 : 0;
    localparam int IDX_LIM  = (SETS_LOG < IDX_CAP) ? SETS_LOG : IDX_CAP;

    acc_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic [3:0] off;
    logic [3:0] ib;
    logic [4:0] sh;
    acc_t       acc;

    assign in_stall = (cnt_reg == 2'd2) || bk.clearing;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rp_reg];

    always_comb
    begin
        off = cfg.offset_bits;
        if (off < 4'(OFF_MIN))
            off = 4'(OFF_MIN);
        else if (off > 4'(OFF_MAX))
            off = 4'(OFF_MAX);
        ib = cfg.index_bits;
        if (ib > 4'(IDX_LIM))
            ib = 4'(IDX_LIM);
        sh = 5'(off) + 5'(ib);
        acc.store    = in_data.op;
        acc.set      = SET_FIELD_W'((in_data.address >> off)
                       & ADDR_WIDTH'((9'd1 << ib) - 9'd1));
        acc.tag      = TAG_W'(in_data.address >> sh);
        acc.blk_cost = BLK_COST_W'(MEM_CYCLES) << (off - 4'(OFF_MIN));
    end

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
            wp_next = !wp_reg;
        if (bk.pop)
            rp_next = !rp_reg;
        if (push && !bk.pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!push && bk.pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= acc;
    end

endmodule
`default_nettype wire

@@ design/sactp_back.sv @@
// Back end: tag memory read-modify-write, replacement policy, statistics.
`default_nettype none
module sactp_back
    import sactp_pkg::*;
#(
    parameter int SETS = DEF_SETS,
    parameter int WAYS = DEF_WAYS
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      q_valid,
    input  wire acc_t      q_item,
    output bk_status_t     bk,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int ENT_W  = 2 + RANK_W + TAG_W;

    typedef logic [WAYS-1:0][ENT_W-1:0] row_t;

    row_t             mem [SETS];
    row_t             rd_row_reg;
    row_t             wr_row_reg;
    row_t             row;
    row_t             new_row;
    logic             bypass_reg;
    logic             rd_pend_reg;
    acc_t             cur_reg;
    logic             clearing_reg;
    logic [SET_W-1:0] clr_idx_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] cnt_reg [4];
    logic [CNT_W-1:0] cnt_next [4];

    logic             out_free, do_b, can_pop;
    logic [SET_W-1:0] q_set, cur_set, wa;
    logic             we;
    row_t             wd;

    logic             v  [WAYS];
    logic             d  [WAYS];
    logic [RANK_W-1:0] rk [WAYS];
    logic [TAG_W-1:0] tg [WAYS];
    logic             nv [WAYS];
    logic             nd [WAYS];
    logic [RANK_W-1:0] nr [WAYS];
    logic [TAG_W-1:0] nt [WAYS];
    logic [WAYS-1:0]  vvec;
    logic             hit, vfound, ffound, full, alloc, wbf;
    logic [WAY_W-1:0] hway, vway, fway, slot;
    logic [RANK_W-1:0] best;
    logic [WAYS_CNT_W-1:0] used, nways;
    logic [COST_W-1:0] cost, blk;
    logic [TOTAL_W:0] sum;
    cnt_sel_t         csel;

    assign q_set   = SET_W'({8'd0, q_item.set});
    assign cur_set = SET_W'({8'd0, cur_reg.set});
    assign out_free = !out_valid_reg || !out_stall;
    assign do_b    = rd_pend_reg && out_free;
    assign can_pop = q_valid && !clearing_reg && (!rd_pend_reg || do_b);
    assign bk.clearing = clearing_reg;
    assign bk.pop      = can_pop;
    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;

    // lookup and policy update on the row read for the current access
    always_comb
    begin
        row = bypass_reg ? wr_row_reg : rd_row_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            v[w]    = row[w][ENT_W-1];
            d[w]    = row[w][ENT_W-2];
            rk[w]   = row[w][TAG_W +: RANK_W];
            tg[w]   = row[w][TAG_W-1:0];
            vvec[w] = row[w][ENT_W-1];
        end
        hit  = 1'b0;
        hway = '0;
        for (int w = 0; w < WAYS; w++)
            if (v[w] && !hit && tg[w] == cur_reg.tag)
            begin
                hit  = 1'b1;
                hway = WAY_W'(w);
            end
        used = WAYS_CNT_W'($countones(vvec));
        vfound = 1'b0;
        best   = '0;
        vway   = '0;
        for (int w = 0; w < WAYS; w++)
            if (v[w] && (!vfound || rk[w] > best))
            begin
                vfound = 1'b1;
                best   = rk[w];
                vway   = WAY_W'(w);
            end
        ffound = 1'b0;
        fway   = '0;
        for (int w = 0; w < WAYS; w++)
            if (!v[w] && !ffound)
            begin
                ffound = 1'b1;
                fway   = WAY_W'(w);
            end
        nways = WAYS_CNT_W'(cfg.ways_in_use);
        if (nways == '0)
            nways = WAYS_CNT_W'(1);
        else if (nways > WAYS_CNT_W'(WAYS))
            nways = WAYS_CNT_W'(WAYS);
        full = (used >= nways);
        slot = full ? vway : fway;
        blk  = COST_W'(cur_reg.blk_cost);

        for (int w = 0; w < WAYS; w++)
        begin
            nv[w] = v[w];
            nd[w] = d[w];
            nr[w] = rk[w];
            nt[w] = tg[w];
        end
        alloc = 1'b0;
        wbf   = 1'b0;
        if (hit)
        begin
            if (cur_reg.store && cfg.copy_back)
                nd[hway] = 1'b1;
            cost = (cur_reg.store && !cfg.copy_back) ? COST_W'(MEM_CYCLES)
                                                     : COST_W'(CACHE_CYCLES);
            if (!cfg.use_fifo)
            begin
                for (int w = 0; w < WAYS; w++)
                    if (v[w] && rk[w] < rk[hway])
                        nr[w] = RANK_W'(rk[w] + 1'b1);
                nr[hway] = '0;
            end
        end
        else if (!cur_reg.store || cfg.store_alloc)
        begin
            alloc = 1'b1;
            if (full)
            begin
                wbf      = cfg.copy_back && d[vway];
                nv[vway] = 1'b0;
            end
            for (int w = 0; w < WAYS; w++)
                if (nv[w])
                    nr[w] = RANK_W'(rk[w] + 1'b1);
            nv[slot] = 1'b1;
            nt[slot] = cur_reg.tag;
            nd[slot] = cur_reg.store && cfg.copy_back;
            nr[slot] = '0;
            cost = (wbf ? blk : '0) + blk
                 + ((cur_reg.store && !cfg.copy_back) ? COST_W'(MEM_CYCLES)
                                                      : COST_W'(CACHE_CYCLES));
        end
        else
        begin
            cost = COST_W'(MEM_CYCLES);
        end
        for (int w = 0; w < WAYS; w++)
            new_row[w] = {nv[w], nd[w], nr[w], nt[w]};

        // saturating statistics
        sum = {1'b0, total_reg} + (TOTAL_W + 1)'(cost);
        total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        if (cur_reg.store)
            csel = hit ? CNT_STORE_HIT : CNT_STORE_MISS;
        else
            csel = hit ? CNT_LOAD_HIT : CNT_LOAD_MISS;
        for (int k = 0; k < 4; k++)
        begin
            cnt_next[k] = cnt_reg[k];
            if (k == int'(csel) && cnt_reg[k] != '1)
                cnt_next[k] = cnt_reg[k] + 1'b1;
        end
    end

    assign we = clearing_reg || do_b;
    assign wa = clearing_reg ? clr_idx_reg : cur_set;
    assign wd = clearing_reg ? '0 : new_row;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (can_pop)
        begin
            rd_row_reg <= mem[q_set];
            cur_reg    <= q_item;
            bypass_reg <= do_b && (q_set == cur_set);
        end
        if (do_b)
        begin
            wr_row_reg <= new_row;
            out_data_reg.hit          <= hit;
            out_data_reg.allocated    <= alloc;
            out_data_reg.wrote_back   <= wbf;
            out_data_reg.cycles_added <= cost;
            out_data_reg.total_cycles <= total_next;
            out_data_reg.load_hits    <= cnt_next[CNT_LOAD_HIT];
            out_data_reg.load_misses  <= cnt_next[CNT_LOAD_MISS];
            out_data_reg.store_hits   <= cnt_next[CNT_STORE_HIT];
            out_data_reg.store_misses <= cnt_next[CNT_STORE_MISS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            for (int k = 0; k < 4; k++)
                cnt_reg[k] <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == SET_W'(SETS - 1))
                    clearing_reg <= 1'b0;
            end
            if (can_pop)
                rd_pend_reg <= 1'b1;
            else if (do_b)
                rd_pend_reg <= 1'b0;
            if (do_b)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_next;
                for (int k = 0; k < 4; k++)
                    cnt_reg[k] <= cnt_next[k];
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

@@ design/set_assoc_cache_tag_policy.sv @@
// Top level of the set-associative cache tag and replacement policy block.
// An accepted access passes the front queue, the row-read registers and the output register.
// Throughput: one access per cycle while the result side takes transfers and no clearing
// pass runs; a row written at one edge is forwarded to a same-set access read at that
// edge, so nothing waits. Reset: config returns to defaults, counters and total clear,
// then a clearing pass writes every tag-memory row while in_stall stays high.
// Config writes are taken during that pass.
`default_nettype none
module set_assoc_cache_tag_policy
    import sactp_pkg::*;
#(
    parameter int SETS = DEF_SETS,
    parameter int WAYS = DEF_WAYS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data
);

    cfg_t       cfg_reg;
    bk_status_t bk;
    logic       q_valid;
    acc_t       q_item;

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits <= 4'd4;
            cfg_reg.index_bits  <= 4'd8;
            cfg_reg.ways_in_use <= 4'd8;
            cfg_reg.store_alloc <= 1'b1;
            cfg_reg.copy_back   <= 1'b1;
            cfg_reg.use_fifo    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_OFFSET_BITS:    cfg_reg.offset_bits <= cfg_data;
                REG_INDEX_BITS:     cfg_reg.index_bits  <= cfg_data;
                REG_WAYS_IN_USE:    cfg_reg.ways_in_use <= cfg_data;
                REG_WRITE_ALLOCATE: cfg_reg.store_alloc <= cfg_data[0];
                REG_WRITE_BACK:     cfg_reg.copy_back   <= cfg_data[0];
                REG_USE_FIFO:       cfg_reg.use_fifo    <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // front: classify and queue (two entries)
    sactp_front #(.SETS(SETS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .bk       (bk),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    // back: row read, compare, policy update, write, stats, output register
    sactp_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .bk        (bk),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

@@ design/sactp_checker.sv @@
// Port-level checker for the cache tag block, bound to the top level.
`default_nettype none
module sactp_checker
    import sactp_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_item_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_wb_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.wrote_back |-> out_data.allocated && !out_data.hit)
        else $error("write-back without a fill");

    a_hit_cost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |-> !out_data.allocated
        && (out_data.cycles_added == COST_W'(CACHE_CYCLES)
            || out_data.cycles_added == COST_W'(MEM_CYCLES)))
        else $error("bad hit result");

    a_noalloc_cost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit && !out_data.allocated
        |-> out_data.cycles_added == COST_W'(MEM_CYCLES))
        else $error("bad no-allocate cost");

endmodule

bind set_assoc_cache_tag_policy sactp_checker u_chk (.*);
`default_nettype wire
